// File: hw/rtl/bbs_pkg.sv
// ============================================================================
// bbs_pkg: shared widths and types for the Bezier splat block
// Field widths of the item channels, fixed-point formats and register map.
// ============================================================================
`default_nettype none

package bbs_pkg;

    // Control point coordinates: whole pixels
    localparam int COORD_W   = 10;
    // Curve parameter: unsigned Q0.16
    localparam int T_W       = 16;
    // Fraction bits of a curve point
    localparam int FRAC_BITS = 16;
    // Curve point: Q10.16
    localparam int PT_W      = COORD_W + FRAC_BITS;
    // Bilinear weight per axis: 0 .. 2^FRAC_BITS
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * WGT_W;

    localparam int PIX_W     = COORD_W + 1;
    localparam int INT_W     = 8;

    localparam int IMAGE_WIDTH  = 700;
    localparam int IMAGE_HEIGHT = 700;

    // Register map: index = 2 * point + axis
    localparam int NUM_PTS   = 4;
    localparam int NUM_AXES  = 2;
    localparam int NUM_REGS  = NUM_PTS * NUM_AXES;
    localparam int CFG_IDX_W = 8;
    localparam int AXIS_X    = 0;
    localparam int AXIS_Y    = 1;

    typedef logic [COORD_W-1:0]   coord_t;
    typedef logic [T_W-1:0]       tfrac_t;
    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [INT_W-1:0]     inten_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

endpackage

`default_nettype wire

// File: hw/rtl/bbs_in_if.sv
// ============================================================================
// bbs_in_if: curve parameter channel
// Carries one t value per item with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface bbs_in_if;
    import bbs_pkg::*;

    logic   valid;
    logic   ready;
    tfrac_t t_frac;

    modport source (output valid, output t_frac, input ready);
    modport sink   (input valid, input t_frac, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bbs_out_if.sv
// ============================================================================
// bbs_out_if: splat result channel
// Carries one splatted pixel per item with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface bbs_out_if;
    import bbs_pkg::*;

    logic   valid;
    logic   ready;
    pix_t   pixel_x;
    pix_t   pixel_y;
    inten_t intensity_add;
    logic   inside_image;
    logic   last_splat;

    modport source (output valid, output pixel_x, output pixel_y, output intensity_add,
                    output inside_image, output last_splat, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input intensity_add,
                    input inside_image, input last_splat, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bbs_cfg_if.sv
// ============================================================================
// bbs_cfg_if: register write channel
// Carries a register index and write data with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface bbs_cfg_if;
    import bbs_pkg::*;

    logic     valid;
    logic     ready;
    cfg_idx_t index;
    coord_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bezier_bilinear_splat.sv
// ============================================================================
// bezier_bilinear_splat: cubic Bezier point splatter
// Evaluates a cubic Bezier curve at t and splats the point onto four pixels.
// ============================================================================
// Usage:
//   cfg     - register writes; index 2*p+axis selects control point p, axis
//             x (0) or y (1). Indexes beyond seven are ignored. Always ready.
//             Write only while the pipeline is empty.
//   curve_t - one t_frac (Q0.16) per item.
//   splat   - four items per t, in the order p00, p10, p01, p11; last_splat
//             marks p11.
// Splats: the other three splats of a t follow the first one per cycle
//   when splat.ready stays high.
// Throughput: the serializer spends four pixels on each t, one per cycle
//   while splat.ready is high; the lerp stages take a t every cycle unless
//   stalled, absorbing up to three t values ahead of the serializer.
// Reset: control points clear to 0 and the pipeline empties.
// Stall: splat.ready low holds the output register; each stage holds its
//   item until the next stage frees, and curve_t.ready drops once the
//   pipeline is full. Nothing is lost or repeated.
// ============================================================================
`default_nettype none

module bezier_bilinear_splat (
    input  wire logic clk,
    input  wire logic rst_n,
    bbs_cfg_if.sink   cfg,
    bbs_in_if.sink    curve_t,
    bbs_out_if.source splat
);
    import bbs_pkg::*;

    localparam logic [1:0] LAST_CNT = 2'b11;
    localparam logic [FRAC_BITS-1:0] FRAC_ZERO = '0;
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_BITS;

    // One linear interpolation: a + floor((b - a) * t / 2^16).
    // Exact match to floor((a*(1-t) + b*t)) because a*2^16 divides evenly.
    function automatic logic [PT_W-1:0] lerp_fx(
        input logic [PT_W-1:0] a,
        input logic [PT_W-1:0] b,
        input tfrac_t          t
    );
        logic signed [PT_W:0]         diff;
        logic signed [PT_W+T_W+1:0]   prod;
        logic        [PT_W+1:0]       sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, t});
        sum  = {2'b00, a} + prod[PT_W+T_W+1:T_W];
        return sum[PT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Control point registers, [axis][point]
    // ------------------------------------------------------------------
    coord_t coord_reg [NUM_AXES][NUM_PTS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                for (int p = 0; p < NUM_PTS; p++)
                begin
                    coord_reg[ax][p] <= '0;
                end
            end
        end
        else if (cfg.valid && (cfg.index < CFG_IDX_W'(NUM_REGS)))
        begin
            coord_reg[cfg.index[0]][cfg.index[2:1]] <= cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // Handshake chain: each stage advances when the next one is free
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, s_valid_reg, p_valid_reg, o_valid_reg;
    logic [1:0] s_cnt_reg;

    logic o_ready, p_ready, s_emit, s_free, st3_ready, st2_ready, st1_ready;

    assign o_ready   = !o_valid_reg || splat.ready;
    assign p_ready   = !p_valid_reg || o_ready;
    assign s_emit    = s_valid_reg && p_ready;
    assign s_free    = !s_valid_reg || (p_ready && (s_cnt_reg == LAST_CNT));
    assign st3_ready = !v3_reg || s_free;
    assign st2_ready = !v2_reg || st3_ready;
    assign st1_ready = !v1_reg || st2_ready;

    assign curve_t.ready = st1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            s_valid_reg <= 1'b0;
            s_cnt_reg   <= '0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (st1_ready)
            begin
                v1_reg <= curve_t.valid;
            end
            if (st2_ready)
            begin
                v2_reg <= v1_reg;
            end
            if (st3_ready)
            begin
                v3_reg <= v2_reg;
            end
            // Serializer: load a new point once the last splat leaves
            if (s_free)
            begin
                s_valid_reg <= v3_reg;
                s_cnt_reg   <= '0;
            end
            else if (s_emit)
            begin
                s_cnt_reg <= s_cnt_reg + 2'b01;
            end
            if (p_ready)
            begin
                p_valid_reg <= s_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: first de Casteljau level from the control points
    // ------------------------------------------------------------------
    logic [PT_W-1:0] l1_reg [NUM_AXES][NUM_PTS-1];
    tfrac_t          t1_reg;

    always_ff @(posedge clk)
    begin
        if (st1_ready && curve_t.valid)
        begin
            t1_reg <= curve_t.t_frac;
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                for (int j = 0; j < NUM_PTS - 1; j++)
                begin
                    l1_reg[ax][j] <= lerp_fx({coord_reg[ax][j], FRAC_ZERO},
                                             {coord_reg[ax][j+1], FRAC_ZERO},
                                             curve_t.t_frac);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: second level
    // ------------------------------------------------------------------
    logic [PT_W-1:0] l2_reg [NUM_AXES][NUM_PTS-2];
    tfrac_t          t2_reg;

    always_ff @(posedge clk)
    begin
        if (st2_ready && v1_reg)
        begin
            t2_reg <= t1_reg;
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                for (int j = 0; j < NUM_PTS - 2; j++)
                begin
                    l2_reg[ax][j] <= lerp_fx(l1_reg[ax][j], l1_reg[ax][j+1], t1_reg);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: final level gives the curve point
    // ------------------------------------------------------------------
    logic [PT_W-1:0] l3_reg [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (st3_ready && v2_reg)
        begin
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                l3_reg[ax] <= lerp_fx(l2_reg[ax][0], l2_reg[ax][1], t2_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: serializer, one neighbor pixel per unstalled cycle
    // ------------------------------------------------------------------
    coord_t                 s_xi_reg, s_yi_reg;
    logic [FRAC_BITS-1:0]   s_xf_reg, s_yf_reg;

    always_ff @(posedge clk)
    begin
        if (s_free && v3_reg)
        begin
            s_xi_reg <= l3_reg[AXIS_X][PT_W-1:FRAC_BITS];
            s_yi_reg <= l3_reg[AXIS_Y][PT_W-1:FRAC_BITS];
            s_xf_reg <= l3_reg[AXIS_X][FRAC_BITS-1:0];
            s_yf_reg <= l3_reg[AXIS_Y][FRAC_BITS-1:0];
        end
    end

    // Count bit 0 steps right, bit 1 steps down
    logic [WGT_W-1:0] wx, wy;
    pix_t             s_px, s_py;

    always_comb
    begin
        wx   = s_cnt_reg[0] ? {1'b0, s_xf_reg} : (WGT_ONE - {1'b0, s_xf_reg});
        wy   = s_cnt_reg[1] ? {1'b0, s_yf_reg} : (WGT_ONE - {1'b0, s_yf_reg});
        s_px = {1'b0, s_xi_reg} + PIX_W'(s_cnt_reg[0]);
        s_py = {1'b0, s_yi_reg} + PIX_W'(s_cnt_reg[1]);
    end

    // ------------------------------------------------------------------
    // Stage 5: bilinear weight product
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] p_w_reg;
    pix_t              p_px_reg, p_py_reg;
    logic              p_last_reg;

    always_ff @(posedge clk)
    begin
        if (s_emit)
        begin
            p_w_reg    <= PROD_W'(wx) * PROD_W'(wy);
            p_px_reg   <= s_px;
            p_py_reg   <= s_py;
            p_last_reg <= (s_cnt_reg == LAST_CNT);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: intensity scale and bounds check, output register
    // ------------------------------------------------------------------
    localparam int SCL_W = PROD_W + INT_W;

    logic [SCL_W-1:0] scaled;
    assign scaled = {p_w_reg, {INT_W{1'b0}}} - {{INT_W{1'b0}}, p_w_reg};

    pix_t   o_px_reg, o_py_reg;
    inten_t o_int_reg;
    logic   o_inside_reg, o_last_reg;

    always_ff @(posedge clk)
    begin
        if (o_ready && p_valid_reg)
        begin
            o_px_reg     <= p_px_reg;
            o_py_reg     <= p_py_reg;
            o_int_reg    <= scaled[2*FRAC_BITS+INT_W-1:2*FRAC_BITS];
            o_inside_reg <= (p_px_reg < PIX_W'(IMAGE_WIDTH))
                         && (p_py_reg < PIX_W'(IMAGE_HEIGHT));
            o_last_reg   <= p_last_reg;
        end
    end

    assign splat.valid         = o_valid_reg;
    assign splat.pixel_x       = o_px_reg;
    assign splat.pixel_y       = o_py_reg;
    assign splat.intensity_add = o_int_reg;
    assign splat.inside_image  = o_inside_reg;
    assign splat.last_splat    = o_last_reg;

endmodule

`default_nettype wire
